/* rtl/core/lslf_pkg.sv */
// shared constants and types for the least squares line fit
`timescale 1ns / 1ps
`default_nettype none
package lslf_pkg;
  localparam int MaxSamples = 1024;
  localparam int CntW = 11;
  localparam int SumW = 27;
  localparam int SxyW = 43;
  localparam int SsqW = 42;
  localparam int WideW = 128;

  // shared unit operations
  typedef enum logic [2:0] {
    OP_MUL,
    OP_MAC_SUB,
    OP_DIV_Q16,
    OP_FRAC
  } lslf_op_t;
endpackage
`default_nettype wire

/* rtl/core/least_squares_line_fit.sv */
// top level of the least squares line fit
// usage:
//  - drive x_sample, y_sample and last with start high; the item is taken
//    at a clock edge where start is high and busy is low
//  - a pair without last is added to the registered sums; busy stays low, so pairs
//    can be taken one per cycle
//  - a pair with last raises busy while one shared shift-add multiplier
//    and shift-subtract divider run the fit: ten products, two divisions
//    and one fraction (the fraction is skipped when r squared needs no
//    division); the next pair can be taken in the cycle after the result
//  - the result shows on slope, intercept, rsq and fit_ok for one
//    cycle with valid high; the receiver cannot stall, so the result
//    must be taken then
//  - the sums clear after the result; the next data set starts clean
//  - pairs beyond the sample limit are dropped and force fit_ok low
//  - rst (synchronous, active high) clears sums and sequencer
`timescale 1ns / 1ps
`default_nettype none
module least_squares_line_fit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] x_sample,
  input  logic signed [15:0] y_sample,
  input  logic               last,
  output logic               valid,
  output logic signed [31:0] slope,
  output logic signed [31:0] intercept,
  output logic [16:0]        rsq,
  output logic               fit_ok
);
  import lslf_pkg::*;
  logic take, running, done;
  logic [CntW-1:0] cnt;
  logic signed [SumW-1:0] sx, sy;
  logic signed [SxyW-1:0] sxy;
  logic signed [SsqW-1:0] sxx, syy;
  logic ovf;

  assign take = start && !busy;
  assign busy = running;
  assign valid = done;

  always_ff @(posedge clk) begin
    if (rst) running <= 1'b0;
    else if (take && last) running <= 1'b1;
    else if (done) running <= 1'b0;
  end

  lslf_accum u_acc (
    .clk(clk), .rst(rst), .add(take), .clear(done),
    .x_sample(x_sample), .y_sample(y_sample),
    .cnt(cnt), .sx(sx), .sy(sy), .sxy(sxy), .sxx(sxx), .syy(syy), .ovf(ovf)
  );

  lslf_solver u_sol (
    .clk(clk), .rst(rst), .go(take && last),
    .cnt(cnt), .sx(sx), .sy(sy), .sxy(sxy), .sxx(sxx), .syy(syy), .ovf(ovf),
    .done(done), .slope(slope), .intercept(intercept),
    .rsq(rsq), .fit_ok(fit_ok)
  );
endmodule
`default_nettype wire

/* rtl/core/lslf_accum.sv */
// running sums of the sample pairs
`timescale 1ns / 1ps
`default_nettype none
module lslf_accum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        add,
  input  logic                        clear,
  input  logic signed [15:0]          x_sample,
  input  logic signed [15:0]          y_sample,
  output logic [lslf_pkg::CntW-1:0]   cnt,
  output logic signed [lslf_pkg::SumW-1:0] sx,
  output logic signed [lslf_pkg::SumW-1:0] sy,
  output logic signed [lslf_pkg::SxyW-1:0] sxy,
  output logic signed [lslf_pkg::SsqW-1:0] sxx,
  output logic signed [lslf_pkg::SsqW-1:0] syy,
  output logic                        ovf
);
  import lslf_pkg::*;
  logic signed [31:0] pxy, pxx, pyy;
  logic full;
  assign pxy = x_sample * y_sample;
  assign pxx = x_sample * x_sample;
  assign pyy = y_sample * y_sample;
  assign full = ({21'd0, cnt} >= 32'(MaxSamples));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cnt <= '0; sx <= '0; sy <= '0; sxy <= '0; sxx <= '0; syy <= '0; ovf <= 1'b0;
    end else if (add) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
        sx  <= sx + SumW'(x_sample);
        sy  <= sy + SumW'(y_sample);
        sxy <= sxy + SxyW'(pxy);
        sxx <= sxx + SsqW'(pxx);
        syy <= syy + SsqW'(pyy);
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/lslf_solver.sv */
// sequencer and shared shift-add multiply / shift-subtract divide unit
`timescale 1ns / 1ps
`default_nettype none
module lslf_solver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [lslf_pkg::CntW-1:0]   cnt,
  input  logic signed [lslf_pkg::SumW-1:0] sx,
  input  logic signed [lslf_pkg::SumW-1:0] sy,
  input  logic signed [lslf_pkg::SxyW-1:0] sxy,
  input  logic signed [lslf_pkg::SsqW-1:0] sxx,
  input  logic signed [lslf_pkg::SsqW-1:0] syy,
  input  logic                        ovf,
  output logic                        done,
  output logic signed [31:0]          slope,
  output logic signed [31:0]          intercept,
  output logic [16:0]                 rsq,
  output logic                        fit_ok
);
  import lslf_pkg::*;
  localparam int W = WideW;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL, S_MDONE, S_DIV, S_DDONE, S_OUT
  } state_t;

  // step list: products then divisions
  typedef enum logic [3:0] {
    K_NXY, K_XY, K_NXX, K_XX, K_NYY, K_YY, K_B1, K_B2, K_RN, K_RD,
    K_SLOPE, K_ICPT, K_R2, K_END
  } step_t;

  state_t state;
  step_t  step;
  logic [W-1:0] ma, mb, acc;   // multiplier operands (magnitudes)
  logic         mneg;
  logic [6:0]   bitc;
  logic signed [W-1:0] num, den_x, den_y, b_num, rnum, rden, tmp;
  logic [W-1:0] dmag, rem, dden;
  logic [40:0]  q;
  logic         dneg;
  logic [7:0]   dcnt;
  logic signed [W-1:0] sa, sb;
  logic [W-1:0] rem_sh, prod;

  // operand selection for each product step
  always_comb begin
    sa = '0; sb = '0;
    unique case (step)
      K_NXY: begin sa = W'($signed({1'b0, cnt})); sb = W'(sxy); end
      K_XY:  begin sa = W'(sx); sb = W'(sy); end
      K_NXX: begin sa = W'($signed({1'b0, cnt})); sb = W'(sxx); end
      K_XX:  begin sa = W'(sx); sb = W'(sx); end
      K_NYY: begin sa = W'($signed({1'b0, cnt})); sb = W'(syy); end
      K_YY:  begin sa = W'(sy); sb = W'(sy); end
      K_B1:  begin sa = W'(sy); sb = W'(sxx); end
      K_B2:  begin sa = W'(sx); sb = W'(sxy); end
      K_RN:  begin sa = num; sb = num; end
      K_RD:  begin sa = den_x; sb = den_y; end
      default: ;
    endcase
  end

  assign prod = mneg ? (~acc + 1'b1) : acc;
  assign rem_sh = {rem[W-2:0], dmag[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; step <= K_NXY; done <= 1'b0;
    end else begin
      done <= (state == S_OUT);
      unique case (state)
        S_IDLE: if (go) begin
          step <= K_NXY; state <= S_LOAD;
        end
        S_LOAD: begin
          ma <= sa[W-1] ? (~sa + 1'b1) : sa;
          mb <= sb[W-1] ? (~sb + 1'b1) : sb;
          mneg <= sa[W-1] ^ sb[W-1];
          acc <= '0; bitc <= '0; state <= S_MUL;
        end
        S_MUL: begin
          // one bit of the multiplier per cycle, 84 bits cover every operand
          if (mb[0]) acc <= acc + ma;
          ma <= ma << 1; mb <= mb >> 1;
          bitc <= bitc + 1'b1;
          if (bitc == 7'd83) state <= S_MDONE;
        end
        S_MDONE: begin
          state <= (step == K_RD) ? S_DIV : S_LOAD;
          step <= step_t'(step + 1'b1);
          unique case (step)
            K_NXY: tmp <= prod;
            K_XY:  num <= tmp - prod;
            K_NXX: tmp <= prod;
            K_XX:  den_x <= tmp - prod;
            K_NYY: tmp <= prod;
            K_YY:  den_y <= tmp - prod;
            K_B1:  tmp <= prod;
            K_B2:  b_num <= tmp - prod;
            K_RN:  rnum <= prod;
            K_RD: begin
              rden <= prod;
              fit_ok <= !ovf && cnt >= CntW'(2) && den_x > 0;
              // slope divide setup
              dneg <= num[W-1];
              dmag <= (num[W-1] ? (~num + 1'b1) : num) << 16;
              dden <= den_x;
              rem <= '0; q <= '0; dcnt <= '0;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          dmag <= dmag << 1;
          dcnt <= dcnt + 1'b1;
          if (step == K_R2) begin
            if (rem_sh >= dden) begin
              rem <= rem_sh - dden; q <= {q[39:0], 1'b1};
            end else begin
              rem <= rem_sh; q <= {q[39:0], 1'b0};
            end
            if (dcnt == 8'd15) state <= S_DDONE;
          end else begin
            // quotient held at 2^40 once it gets there
            if (rem_sh >= dden) begin
              rem <= rem_sh - dden;
              q <= ({q, 1'b1} > 42'h100_0000_0000) ? 41'h100_0000_0000
                   : {q[39:0], 1'b1};
            end else begin
              rem <= rem_sh;
              q <= ({q, 1'b0} > 42'h100_0000_0000) ? 41'h100_0000_0000
                   : {q[39:0], 1'b0};
            end
            if (dcnt == 8'd127) state <= S_DDONE;
          end
        end
        S_DDONE: begin
          unique case (step)
            K_SLOPE: begin
              slope <= dneg ? ((q >= 41'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]))
                            : ((q > 41'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]));
              rem <= '0; q <= '0; dcnt <= '0;
              dneg <= b_num[W-1];
              dmag <= (b_num[W-1] ? (~b_num + 1'b1) : b_num) << 8;
              step <= K_ICPT; state <= S_DIV;
            end
            K_ICPT: begin
              intercept <= dneg ? ((q >= 41'h8000_0000) ? 32'sh8000_0000
                                   : -$signed(q[31:0]))
                                : ((q > 41'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]));
              step <= K_R2;
              dcnt <= '0;
              if (den_y <= 0 || rnum >= rden) begin
                q <= 41'd65536; state <= S_DDONE;
              end else begin
                // fraction: numerator below denominator, shift it in from the remainder
                q <= '0;
                rem <= rnum; dmag <= '0; dden <= rden; state <= S_DIV;
              end
            end
            default: begin
              rsq <= q[16:0];
              step <= K_END; state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!fit_ok) begin
            slope <= '0; intercept <= '0; rsq <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the least squares line fit
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               lst;
  } pair_t;

  typedef struct {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [16:0]        r_sq;
    logic               ok;
  } fit_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] x_sample;
  logic signed [15:0] y_sample;
  logic               last;
  logic               valid;
  logic signed [31:0] slope;
  logic signed [31:0] intercept;
  logic [16:0]        rsq;
  logic               fit_ok;

  pair_t pending_pairs[$];
  fit_t  expected_fits[$];
  int    send_idle_pct;
  int    errors;
  int    pairs_taken;
  int    fits_checked;
  int    invalid_fits;

  // predictor state
  int    n_acc;
  longint acc_x, acc_y, acc_xy, acc_xx, acc_yy;
  bit    dropped;

  least_squares_line_fit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_sample(x_sample), .y_sample(y_sample), .last(last),
    .valid(valid), .slope(slope), .intercept(intercept),
    .rsq(rsq), .fit_ok(fit_ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // trunc(num * 2^sh / den), saturated to the signed 32-bit range (q16.16 when sh is 16)
  function automatic logic [31:0] q16_quot(logic signed [127:0] num, logic [127:0] den,
                                           int sh);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag << sh) / den;
    if (num < 0) begin
      if (q >= 128'h8000_0000) return 32'h8000_0000;
      return -q[31:0];
    end
    if (q > 128'h7fff_ffff) return 32'h7fff_ffff;
    return q[31:0];
  endfunction

  function automatic fit_t solve_fit();
    fit_t f;
    longint n, den_x, den_y, num;
    logic signed [127:0] icpt_num;
    logic [127:0] num_sq, den_prod, num_mag;
    n = n_acc;
    den_x = n * acc_xx - acc_x * acc_x;
    den_y = n * acc_yy - acc_y * acc_y;
    num = n * acc_xy - acc_x * acc_y;
    f = '{slope: 0, intercept: 0, r_sq: 0, ok: 0};
    if (dropped || n < 2 || den_x <= 0) return f;
    f.ok = 1'b1;
    icpt_num = 128'(acc_y) * 128'(acc_xx) - 128'(acc_x) * 128'(acc_xy);
    f.slope = q16_quot(128'(num), 128'(den_x), 16);
    f.intercept = q16_quot(icpt_num, 128'(den_x), 8);
    num_mag = (num < 0) ? 128'(-num) : 128'(num);
    num_sq = num_mag * num_mag;
    den_prod = 128'(den_x) * 128'(den_y);
    if (den_y <= 0 || num_sq >= den_prod) f.r_sq = 17'd65536;
    else f.r_sq = 17'((num_sq << 16) / den_prod);
    return f;
  endfunction

  task automatic clear_sums();
    n_acc = 0;
    acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
    dropped = 0;
  endtask

  // accept side: predict on every taken item
  always @(posedge clk) begin
    pair_t p;
    longint xv, yv;
    if (!rst && start && !busy && pending_pairs.size() > 0) begin
      p = pending_pairs.pop_front();
      pairs_taken++;
      xv = p.x;
      yv = p.y;
      if (n_acc < lslf_pkg::MaxSamples) begin
        acc_x += xv; acc_y += yv; acc_xy += xv * yv;
        acc_xx += xv * xv; acc_yy += yv * yv;
        n_acc++;
      end else begin
        dropped = 1;
      end
      if (p.lst) begin
        expected_fits.push_back(solve_fit());
        clear_sums();
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst || pending_pairs.size() == 0 || $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      x_sample <= 16'($urandom);
      y_sample <= 16'($urandom);
      last <= 1'($urandom);
    end else begin
      start <= 1'b1;
      x_sample <= pending_pairs[0].x;
      y_sample <= pending_pairs[0].y;
      last <= pending_pairs[0].lst;
    end
  end

  // monitor
  always @(posedge clk) begin
    fit_t e;
    if (!rst && valid) begin
      if (expected_fits.size() == 0) begin
        $error("result with no expectation pending");
        errors++;
      end else begin
        e = expected_fits.pop_front();
        fits_checked++;
        if (!e.ok) invalid_fits++;
        if (fit_ok !== e.ok) begin
          $error("fit_ok: expected %0d, got %0d", e.ok, fit_ok); errors++;
        end
        if (slope !== e.slope) begin
          $error("slope: expected %0d, got %0d", e.slope, slope); errors++;
        end
        if (intercept !== e.intercept) begin
          $error("intercept: expected %0d, got %0d", e.intercept, intercept); errors++;
        end
        if (rsq !== e.r_sq) begin
          $error("rsq: expected %0d, got %0d", e.r_sq, rsq); errors++;
        end
      end
    end
  end

  task automatic add_pair(int x, int y, bit lst);
    pending_pairs.push_back('{x: 16'(x), y: 16'(y), lst: lst});
  endtask

  // one data set; kind picks the shape of the samples
  task automatic add_set(int cnt, int kind);
    int a, b, x;
    a = $urandom_range(0, 1023) - 512;
    b = $urandom_range(0, 8191) - 4096;
    for (int i = 0; i < cnt; i++) begin
      x = $urandom_range(0, 4095) - 2048;
      case (kind)
        0: add_pair($urandom, $urandom, i == cnt - 1);
        1: add_pair(x, (a * x) / 256 + b + $urandom_range(0, 63) - 32, i == cnt - 1);
        2: add_pair(b, $urandom, i == cnt - 1);
        default: add_pair($urandom, b, i == cnt - 1);
      endcase
    end
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0);
    wait (expected_fits.size() == 0);
  endtask

  initial begin
    int pct[4];
    errors = 0; pairs_taken = 0; fits_checked = 0; invalid_fits = 0;
    send_idle_pct = 0;
    clear_sums();
    start = 1'b0; x_sample = '0; y_sample = '0; last = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // single pair gives no fit
    add_pair(100, 200, 1);
    // extremes on both fields
    add_pair(-32768, -32768, 0);
    add_pair(32767, 32767, 1);
    add_pair(-32768, 32767, 0);
    add_pair(32767, -32768, 1);
    // steep slope saturates
    add_pair(0, -32768, 0);
    add_pair(1, 32767, 1);
    add_pair(-1, 32767, 0);
    add_pair(0, -32768, 1);
    // constant x, zero denominator
    add_pair(300, 5, 0); add_pair(300, -70, 0); add_pair(300, 9, 1);
    // constant y, r squared of one
    add_pair(-5, 77, 0); add_pair(40, 77, 0); add_pair(900, 77, 1);
    // exact line
    add_pair(0, 256, 0); add_pair(256, 768, 0); add_pair(512, 1280, 1);
    // zero samples
    add_pair(0, 0, 0); add_pair(0, 0, 1);
    drain();

    pct = '{0, 62, 0, 31};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct[ph];
      for (int s = 0; s < 11; s++)
        add_set($urandom_range(1, 20), ($urandom_range(99) < 60) ? 1 : $urandom_range(0, 3));
      if (ph == 2) add_set(lslf_pkg::MaxSamples + 1, 1);  // one pair past the limit
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d pairs and %0d fits (%0d invalid), incl. saturation,",
             pairs_taken, fits_checked, invalid_fits);
    $display("constant x/y, single pair and sample-limit overflow sets");
    if (errors == 0 && expected_fits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
rtl/core/lslf_pkg.sv
rtl/core/lslf_accum.sv
rtl/core/lslf_solver.sv
rtl/core/least_squares_line_fit.sv
tb/tb.sv
